// File: rtl/core/sorted_priority_queue_assert.svh
// Assertion macros used by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Condition that must hold in the same cycle as the trigger.
`define SPQ_ASSERT_NOW(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
        else $error("sorted priority queue check failed");

// Condition that must hold in the cycle after the trigger.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error("sorted priority queue check failed");

`else

`define SPQ_ASSERT_NOW(lbl, clk, rst_n, trig, cond)
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, trig, cond)

`endif

`endif

// File: rtl/core/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int KEY_IO_WIDTH = 32;
    localparam int COUNT_WIDTH  = 5;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Broadcast control seen by every cell of the chain.
    typedef struct packed {
        logic ins;
        logic ext;
        logic smallest_first;
    } t_cell_ctrl;

endpackage

// File: rtl/core/spq_if.sv
// Request and response channel interfaces of the sorted priority queue.
`timescale 1ns / 1ps

interface spq_in_if;
    logic                             valid;
    logic                             ready;
    logic                             opcode;
    logic [spq_pkg::KEY_IO_WIDTH-1:0] key_in;

    modport source (output valid, output opcode, output key_in, input ready);
    modport sink (input valid, input opcode, input key_in, output ready);
endinterface

interface spq_out_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic [spq_pkg::KEY_IO_WIDTH-1:0] key_out;
    logic [spq_pkg::COUNT_WIDTH-1:0]  entry_count;
    logic                             queue_empty;

    modport source (output valid, output status, output key_out, output entry_count,
                    output queue_empty, input ready);
    modport sink (input valid, input status, input key_out, input entry_count,
                  input queue_empty, output ready);
endinterface

// File: rtl/core/spq_cell.sv
// One slot of the sorted chain: holds a key and shifts with its neighbours.
`timescale 1ns / 1ps

module spq_cell #(
    parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  spq_pkg::t_cell_ctrl   i_ctrl,
    input  logic [KEY_WIDTH-1:0]  i_key_new,
    input  logic                  i_occupied,
    input  logic [KEY_WIDTH-1:0]  i_left_key,
    input  logic                  i_left_take,
    input  logic [KEY_WIDTH-1:0]  i_right_key,
    output logic [KEY_WIDTH-1:0]  o_key,
    output logic                  o_take
);

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;
    logic                 above;

    assign above  = i_ctrl.smallest_first ? (i_key_new < r_key) : (i_key_new > r_key);
    // Along a sorted chain the cells that take form a suffix; the first of them
    // receives the new key and the rest take their left neighbour's key.
    assign o_take = !i_occupied || above;
    assign o_key  = r_key;

    always_comb begin
        n_key = r_key;
        if (i_ctrl.ext) begin
            n_key = i_right_key;
        end else if (i_ctrl.ins && o_take) begin
            n_key = i_left_take ? i_left_key : i_key_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

// File: rtl/core/sorted_priority_queue.sv
// Sorted priority queue: a row of compare-and-shift cells with its control.
//
// Requests arrive on i_req (opcode, key_in) with a valid/ready handshake; each
// request produces exactly one response on o_rsp (status, key_out, entry_count,
// queue_empty). Opcode insert places the key behind all entries that rank at
// least as high, so equal keys leave in arrival order; opcode extract removes
// the head. An insert into a full queue is dropped with status full, and an
// extract from an empty queue returns key 0 with status empty.
// i_cfg_we with i_cfg_wdata selects the order: 0 largest first, 1 smallest
// first; write it only while no request is outstanding.
// Every cell compares the broadcast key against its own entry and shifts in the
// cycle the request is taken, and its response is registered; one request is
// taken each cycle while o_rsp does not stall.
// The response register decouples the sides: a new request is taken while the
// response is being taken or the register is empty. If o_rsp stalls, one
// response is held and further requests wait.
// Reset clears the entry count, the order register and the response valid;
// the cell contents need no reset as slots beyond the count are never read.
`timescale 1ns / 1ps

`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    spq_in_if.sink     i_req,
    spq_out_if.source  o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                 r_smallest_first;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_out_valid;
    spq_pkg::t_status     r_status;
    spq_pkg::t_status     n_status;
    logic [KEY_WIDTH-1:0] r_key_out;
    logic [KEY_WIDTH-1:0] n_key_out;
    logic [CW-1:0]        r_out_count;

    logic                 acc;
    logic                 full;
    logic                 empty;
    logic                 ins;
    logic                 ext;
    logic [63:0]          key_in_ext;
    logic [63:0]          key_out_ext;
    logic [8:0]           count_ext;
    logic [KEY_WIDTH-1:0] key_new;
    spq_pkg::t_cell_ctrl  ctrl;

    logic [KEY_WIDTH-1:0] w_key  [DEPTH];
    logic                 w_take [DEPTH];

    assign acc   = i_req.valid && i_req.ready;
    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);
    assign ins   = acc && (i_req.opcode == spq_pkg::OP_INSERT) && !full;
    assign ext   = acc && (i_req.opcode == spq_pkg::OP_EXTRACT) && !empty;

    assign i_req.ready = !r_out_valid || o_rsp.ready;

    assign key_in_ext = {32'b0, i_req.key_in};
    assign key_new    = key_in_ext[KEY_WIDTH-1:0];

    assign ctrl.ins            = ins;
    assign ctrl.ext            = ext;
    assign ctrl.smallest_first = r_smallest_first;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [KEY_WIDTH-1:0] left_key;
        logic                 left_take;
        logic [KEY_WIDTH-1:0] right_key;

        if (i == 0) begin : g_head
            assign left_key  = key_new;
            assign left_take = 1'b0;
        end else begin : g_body
            assign left_key  = w_key[i-1];
            assign left_take = w_take[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_key = '0;
        end else begin : g_inner
            assign right_key = w_key[i+1];
        end

        spq_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_key_new   (key_new),
            .i_occupied  (r_count > CW'(i)),
            .i_left_key  (left_key),
            .i_left_take (left_take),
            .i_right_key (right_key),
            .o_key       (w_key[i]),
            .o_take      (w_take[i])
        );
    end

    always_comb begin
        n_count = r_count;
        if (ins) begin
            n_count = r_count + CW'(1);
        end else if (ext) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_status  = spq_pkg::ST_OK;
        n_key_out = '0;
        if (i_req.opcode == spq_pkg::OP_INSERT) begin
            if (full) begin
                n_status = spq_pkg::ST_FULL;
            end
        end else if (empty) begin
            n_status = spq_pkg::ST_EMPTY;
        end else begin
            n_key_out = w_key[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smallest_first <= 1'b0;
            r_count          <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_smallest_first <= i_cfg_wdata;
            end
            r_count <= n_count;
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_status    <= n_status;
            r_key_out   <= n_key_out;
            r_out_count <= n_count;
        end
    end

    assign key_out_ext = 64'(r_key_out);
    assign count_ext   = 9'(r_out_count);

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.key_out     = key_out_ext[31:0];
    assign o_rsp.entry_count = count_ext[4:0];
    assign o_rsp.queue_empty = (r_out_count == '0);

    `SPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `SPQ_ASSERT_NEXT(a_ins_grows, i_clk, i_rst_n, ins, r_count == $past(r_count) + CW'(1))
    `SPQ_ASSERT_NEXT(a_rsp_follows, i_clk, i_rst_n, acc, r_out_valid && (r_out_count == r_count))
    `SPQ_ASSERT_NOW(a_no_double_op, i_clk, i_rst_n, 1'b1, !(ins && ext))

endmodule
